>>> src/nct_pkg.sv
// Package for the neighbor cache table: field widths, status codes and defaults.
// Used by the channel interfaces, the generic RAM users and the top level.
package nct_pkg;

  // Payload field widths.
  localparam int unsigned OpW     = 1;
  localparam int unsigned IpHalfW = 64;
  localparam int unsigned MacW    = 48;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned KeyW    = 2 * IpHalfW;

  // Default number of table entries.
  localparam int unsigned DefEntries = 16;

  // Operation codes on the request channel.
  localparam logic [OpW-1:0] OpUpdate = 1'b0;
  localparam logic [OpW-1:0] OpLookup = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StInserted = 2'd1,
    StMiss     = 2'd2,
    StFull     = 2'd3
  } status_e;

endpackage

>>> src/nct_req_if.sv
// Request channel interface for the neighbor cache table.
// Depends on nct_pkg for the field widths.
interface nct_req_if;
  logic                        valid;
  logic                        ready;
  logic [nct_pkg::OpW-1:0]     op;
  logic [nct_pkg::IpHalfW-1:0] ip_high;
  logic [nct_pkg::IpHalfW-1:0] ip_low;
  logic [nct_pkg::MacW-1:0]    mac_in;

  modport source (output valid, op, ip_high, ip_low, mac_in, input ready);
  modport sink   (input valid, op, ip_high, ip_low, mac_in, output ready);
endinterface

>>> src/nct_rsp_if.sv
// Result channel interface for the neighbor cache table.
// Depends on nct_pkg for the field widths.
interface nct_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nct_pkg::StatusW-1:0] status;
  logic [nct_pkg::MacW-1:0]    mac_found;
  logic [nct_pkg::SlotW-1:0]   entry_slot;

  modport source (output valid, status, mac_found, entry_slot, input ready);
  modport sink   (input valid, status, mac_found, entry_slot, output ready);
endinterface

>>> src/nct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/neighbor_cache_table_core.sv
// Top level of the IPv6 neighbor cache: scan controller, key RAM and MAC RAM.
// Depends on nct_pkg, nct_req_if, nct_rsp_if and nct_ram.
//
//   channel  direction  payload                        transaction
//   req_i    in         op, ip_high, ip_low, mac_in    valid && ready
//   rsp_o    out        status, mac_found, entry_slot  valid && ready
//
// The read of entry 0 is issued at the accepting edge, then one entry is compared per cycle
// from the pipelined key RAM read port, and the done state loads the result register.
// A hit at slot k ends the scan there; a miss, insert or drop scans every stored entry
// first. The idle state follows the done state before the next acceptance.
// A new request is accepted while the previous result still waits; it stalls
// in the done state only if that result has not been taken. Reset clears the
// entry count and the control state; RAM contents are not cleared.
module neighbor_cache_table_core #(
  parameter int unsigned Entries = nct_pkg::DefEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nct_req_if.sink   req_i,
  nct_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW  = $clog2(Entries + 1);
  localparam int unsigned SlotExtW =
      (AddrW > nct_pkg::SlotW) ? AddrW : nct_pkg::SlotW;

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Done
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic [nct_pkg::OpW-1:0]       op_q;
  logic [nct_pkg::KeyW-1:0]      key_q;
  logic [nct_pkg::MacW-1:0]      mac_q;
  nct_pkg::status_e              res_status_q, res_status_d;
  logic [nct_pkg::MacW-1:0]      res_mac_q, res_mac_d;
  logic [AddrW-1:0]              res_slot_q, res_slot_d;
  logic                          out_valid_q;
  nct_pkg::status_e              out_status_q;
  logic [nct_pkg::MacW-1:0]      out_mac_q;
  logic [nct_pkg::SlotW-1:0]     out_slot_q;

  logic                          req_fire;
  logic                          out_free;
  logic                          hit;
  logic                          last;
  logic [CntW-1:0]               idx_inc;
  logic [AddrW-1:0]              rd_addr;
  logic                          key_we;
  logic                          mac_we;
  logic [AddrW-1:0]              wr_addr;
  logic [nct_pkg::KeyW-1:0]      key_rdata;
  logic [nct_pkg::MacW-1:0]      mac_rdata;
  logic [SlotExtW-1:0]           slot_ext;

  assign req_i.ready = (state_q == Idle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Compare stage: the RAM output belongs to entry idx_q during a scan.
  assign idx_inc = idx_q + CntW'(1);
  assign hit     = (idx_q < count_q) && (key_rdata == key_q);
  assign last    = (idx_inc >= count_q);

  // Next-state logic for the scan, the RAM accesses and the result.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_mac_d    = res_mac_q;
    res_slot_d   = res_slot_q;
    rd_addr      = idx_inc[AddrW-1:0];
    key_we       = 1'b0;
    mac_we       = 1'b0;
    wr_addr      = idx_q[AddrW-1:0];
    unique case (state_q)
      Idle: begin
        rd_addr = '0;
        if (req_fire) begin
          idx_d   = '0;
          state_d = Scan;
        end
      end
      Scan: begin
        if (hit) begin
          res_status_d = nct_pkg::StOk;
          res_slot_d   = idx_q[AddrW-1:0];
          if (op_q == nct_pkg::OpLookup) begin
            res_mac_d = mac_rdata;
          end else begin
            res_mac_d = '0;
            mac_we    = 1'b1;
          end
          state_d = Done;
        end else if (last) begin
          res_mac_d  = '0;
          res_slot_d = '0;
          if (op_q == nct_pkg::OpLookup) begin
            res_status_d = nct_pkg::StMiss;
          end else if (count_q < CntW'(Entries)) begin
            // Append the new pair at the first free slot.
            res_status_d = nct_pkg::StInserted;
            res_slot_d   = count_q[AddrW-1:0];
            wr_addr      = count_q[AddrW-1:0];
            key_we       = 1'b1;
            mac_we       = 1'b1;
            count_d      = count_q + CntW'(1);
          end else begin
            res_status_d = nct_pkg::StFull;
          end
          state_d = Done;
        end else begin
          idx_d = idx_inc;
        end
      end
      Done: begin
        if (out_free) begin
          state_d = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  assign slot_ext = SlotExtW'(res_slot_q);

  // State, request latch and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      res_status_q <= res_status_d;
      res_mac_q    <= res_mac_d;
      res_slot_q   <= res_slot_d;
      if (req_fire) begin
        op_q  <= req_i.op;
        key_q <= {req_i.ip_high, req_i.ip_low};
        mac_q <= req_i.mac_in;
      end
      if (state_q == Done && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_mac_q    <= res_mac_q;
        out_slot_q   <= slot_ext[nct_pkg::SlotW-1:0];
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.mac_found  = out_mac_q;
  assign rsp_o.entry_slot = out_slot_q;

  // Key and MAC stores share the read address. Writes land in the final scan
  // cycle and the next request reads only after the done and idle states, so no
  // forwarding is needed.
  nct_ram #(
    .Width (nct_pkg::KeyW),
    .Depth (Entries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_addr),
    .wdata_i (key_q),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  nct_ram #(
    .Width (nct_pkg::MacW),
    .Depth (Entries)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (mac_we),
    .waddr_i (wr_addr),
    .wdata_i (mac_q),
    .raddr_i (rd_addr),
    .rdata_o (mac_rdata)
  );

`ifndef NO_ASSERTIONS
  // The entry count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Entries))
    else $error("entry count exceeds table size");

  // A key write always grows the entry count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      key_we |=> count_q == $past(count_q) + CntW'(1))
    else $error("key write without count increment");

  // Leaving the done state always loads a new result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == Done && out_free) |=> out_valid_q)
    else $error("result not loaded from done state");

  // No request is accepted while a scan is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == Scan) |-> !req_fire)
    else $error("request accepted during scan");
`endif

endmodule
